// File: design/tpsa_pkg.sv
// ----------------------------------------------------------------------------
// tpsa_pkg
// Shared types and constants for the touch pointer slot allocator.
// ----------------------------------------------------------------------------
package tpsa_pkg;

  localparam int SlotCountDefault = 10;

  // Configuration register indexes
  localparam logic [0:0] CfgScreenWidth  = 1'b0;
  localparam logic [0:0] CfgScreenHeight = 1'b1;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_MOVE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ACT_DOWN     = 3'd0,
    ACT_UP       = 3'd1,
    ACT_MOVE     = 3'd2,
    ACT_PTR_DOWN = 3'd3,
    ACT_PTR_UP   = 3'd4,
    ACT_CANCEL   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_step;
    logic alloc;
    logic take_hit;
    logic cancel;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// File: design/touch_pointer_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// touch_pointer_slot_allocator_core
// Maps touch requests onto pointer slots and scales positions to pixels.
// ----------------------------------------------------------------------------
// One request is in work at a time. A down request is accepted, then takes
// the lowest free slot (with none free it clears every slot and reports
// cancel), then loads its result into the output register. An up or move
// request is settled by the id lookup, which reads the stored finger ids one
// slot a cycle through the single read port of the id RAM and stops at the
// first busy slot that matches. Undefined kinds are accepted and dropped
// with no result. A finished result waits in the output register without
// blocking the next request; the next result waits if that register is
// still stalled. No clearing pass runs after reset.
module touch_pointer_slot_allocator_core #(
  parameter int SLOT_COUNT = tpsa_pkg::SlotCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  event_kind_i,
  input  logic [63:0] finger_id_i,
  input  logic [16:0] pos_x_norm_i,
  input  logic [16:0] pos_y_norm_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [3:0]  pointer_index_o,
  output logic [15:0] point_x_o,
  output logic [15:0] point_y_o
);

  tpsa_pkg::ctrl_cmd_t cmd;
  tpsa_pkg::dp_sts_t   sts;

  tpsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .event_kind_i(event_kind_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tpsa_dp #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .event_kind_i   (event_kind_i),
    .finger_id_i    (finger_id_i),
    .pos_x_norm_i   (pos_x_norm_i),
    .pos_y_norm_i   (pos_y_norm_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .pointer_index_o(pointer_index_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o)
  );

endmodule

// File: design/tpsa_ram.sv
// ----------------------------------------------------------------------------
// tpsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpsa_ram #(
  parameter int Width = 64,
  parameter int Depth = 10,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tpsa_ctrl.sv
// ----------------------------------------------------------------------------
// tpsa_ctrl
// Request sequencer: accept, allocate or scan, then hand the result over.
// ----------------------------------------------------------------------------
module tpsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          event_kind_i,
  input  tpsa_pkg::dp_sts_t   sts_i,
  output tpsa_pkg::ctrl_cmd_t cmd_o
);

  tpsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpsa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tpsa_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (event_kind_i)
            tpsa_pkg::KIND_DOWN: begin
              state_d = tpsa_pkg::ST_ALLOC;
            end
            tpsa_pkg::KIND_UP, tpsa_pkg::KIND_MOVE: begin
              cmd_o.scan_start = 1'b1;
              state_d          = tpsa_pkg::ST_SCAN;
            end
            default: begin
              // drop undefined kind, no result
              state_d = tpsa_pkg::ST_IDLE;
            end
          endcase
        end
      end
      tpsa_pkg::ST_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = tpsa_pkg::ST_RESULT;
      end
      tpsa_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d        = tpsa_pkg::ST_RESULT;
        end else if (sts_i.scan_done) begin
          cmd_o.cancel = 1'b1;
          state_d      = tpsa_pkg::ST_RESULT;
        end
      end
      tpsa_pkg::ST_RESULT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = tpsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tpsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/tpsa_dp.sv
// ----------------------------------------------------------------------------
// tpsa_dp
// Slot table, id lookup scan, coordinate scaling and output register.
// ----------------------------------------------------------------------------
module tpsa_dp #(
  parameter int SLOT_COUNT = tpsa_pkg::SlotCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [1:0]          event_kind_i,
  input  logic [63:0]         finger_id_i,
  input  logic [16:0]         pos_x_norm_i,
  input  logic [16:0]         pos_y_norm_i,
  input  tpsa_pkg::ctrl_cmd_t cmd_i,
  output tpsa_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          action_o,
  output logic [3:0]          pointer_index_o,
  output logic [15:0]         point_x_o,
  output logic [15:0]         point_y_o
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  // configuration
  logic [15:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tpsa_pkg::CfgScreenWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == tpsa_pkg::CfgScreenHeight) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // captured request
  logic [1:0]  kind_q;
  logic [63:0] id_q;
  logic [16:0] pos_x_q, pos_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= event_kind_i;
      id_q    <= finger_id_i;
      pos_x_q <= pos_x_norm_i;
      pos_y_q <= pos_y_norm_i;
    end
  end

  // scaling products, one multiplier each, registered
  logic [32:0] prod_x_q, prod_y_q;

  always_ff @(posedge clk_i) begin
    prod_x_q <= 33'(pos_x_q) * 33'(width_q);
    prod_y_q <= 33'(pos_y_q) * 33'(height_q);
  end

  logic [15:0] pix_x, pix_y;
  assign pix_x = prod_x_q[32] ? 16'hFFFF : prod_x_q[31:16];
  assign pix_y = prod_y_q[32] ? 16'hFFFF : prod_y_q[31:16];

  // lowest free slot
  logic [SLOT_COUNT-1:0] busy_q;
  logic                  free_found;
  logic [IdxW-1:0]       free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // id scan: read slot n while comparing slot n-1
  logic [CntW-1:0] rd_cnt_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            scan_more;
  logic [63:0]     rd_data;

  assign scan_more = (rd_cnt_q != CntW'(SLOT_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else if (cmd_i.scan_start) begin
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      cmp_vld_q <= scan_more;
      if (scan_more) begin
        rd_cnt_q  <= rd_cnt_q + CntW'(1);
        cmp_idx_q <= rd_cnt_q[IdxW-1:0];
      end
    end
  end

  tpsa_ram #(
    .Width(64),
    .Depth(SLOT_COUNT)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.alloc && free_found),
    .waddr_i(free_idx),
    .wdata_i(id_q),
    .re_i   (cmd_i.scan_step && scan_more),
    .raddr_i(rd_cnt_q[IdxW-1:0]),
    .rdata_o(rd_data)
  );

  logic                  hit;
  logic [SLOT_COUNT-1:0] busy_left;

  assign hit       = cmp_vld_q && busy_q[cmp_idx_q] && (rd_data == id_q);
  assign busy_left = busy_q & ~(SLOT_COUNT'(1) << cmp_idx_q);

  // slot state and pending result
  tpsa_pkg::action_e res_action_q;
  logic [3:0]        res_index_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (cmd_i.alloc) begin
      if (free_found) begin
        busy_q[free_idx] <= 1'b1;
      end else begin
        busy_q <= '0;
      end
    end else if (cmd_i.take_hit) begin
      if (kind_q == tpsa_pkg::KIND_UP) begin
        busy_q <= busy_left;
      end
    end else if (cmd_i.cancel) begin
      busy_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      if (free_found) begin
        res_action_q <= (|busy_q) ? tpsa_pkg::ACT_PTR_DOWN : tpsa_pkg::ACT_DOWN;
        res_index_q  <= 4'(free_idx);
      end else begin
        res_action_q <= tpsa_pkg::ACT_CANCEL;
        res_index_q  <= '0;
      end
    end else if (cmd_i.take_hit) begin
      if (kind_q == tpsa_pkg::KIND_UP) begin
        res_action_q <= (|busy_left) ? tpsa_pkg::ACT_PTR_UP : tpsa_pkg::ACT_UP;
      end else begin
        res_action_q <= tpsa_pkg::ACT_MOVE;
      end
      res_index_q <= 4'(cmp_idx_q);
    end else if (cmd_i.cancel) begin
      res_action_q <= tpsa_pkg::ACT_CANCEL;
      res_index_q  <= '0;
    end
  end

  // output register
  logic        out_valid_q;
  logic [2:0]  out_action_q;
  logic [3:0]  out_index_q;
  logic [15:0] out_x_q, out_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_action_q <= res_action_q;
      out_index_q  <= res_index_q;
      out_x_q      <= pix_x;
      out_y_q      <= pix_y;
    end
  end

  assign sts_o.hit       = hit;
  assign sts_o.scan_done = !cmp_vld_q && !scan_more;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_action_q;
  assign pointer_index_o = out_index_q;
  assign point_x_o       = out_x_q;
  assign point_y_o       = out_y_q;

endmodule

// File: design/tpsa_chk.sv
// ----------------------------------------------------------------------------
// tpsa_chk
// Port-level checks for the touch pointer slot allocator.
// ----------------------------------------------------------------------------
module tpsa_chk #(
  parameter int SLOT_COUNT = tpsa_pkg::SlotCountDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  event_kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [3:0]  pointer_index_o
);

  logic kind_known;

  assign kind_known = (event_kind_i == tpsa_pkg::KIND_DOWN) ||
                      (event_kind_i == tpsa_pkg::KIND_UP) ||
                      (event_kind_i == tpsa_pkg::KIND_MOVE);

  // a result held back by stall stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted request of a known kind keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_known |=> in_stall_o)
    else $error("request accepted while previous one in work");

  // cancel always reports slot zero
  a_cancel_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == tpsa_pkg::ACT_CANCEL) |-> (pointer_index_o == 4'd0))
    else $error("cancel with nonzero index");

  // reported slot lies inside the table
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(pointer_index_o) < SLOT_COUNT))
    else $error("slot index out of range");

endmodule

bind touch_pointer_slot_allocator_core tpsa_chk #(
  .SLOT_COUNT(SLOT_COUNT)
) u_tpsa_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .event_kind_i   (event_kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .pointer_index_o(pointer_index_o)
);

// File: tb/sv/touch_result_checker.sv
// ----------------------------------------------------------------------------
// touch_result_checker
// Watches the request, result and register ports of the touch pointer slot
// allocator. It keeps its own slot table to predict each result, compares
// every result field by field and reports the mismatch count and the number
// of results still outstanding.
// ----------------------------------------------------------------------------
module touch_result_checker #(
  parameter int SLOT_COUNT = tpsa_pkg::SlotCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  event_kind_i,
  input  logic [63:0] finger_id_i,
  input  logic [16:0] pos_x_norm_i,
  input  logic [16:0] pos_y_norm_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  action_i,
  input  logic [3:0]  pointer_index_i,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tpsa_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    action_e     action;
    logic [3:0]  slot;
    logic [15:0] px;
    logic [15:0] py;
  } pointer_result_t;

  logic [15:0]           screen_w;
  logic [15:0]           screen_h;
  logic [SLOT_COUNT-1:0] busy_slots;
  logic [63:0]           held_id [SLOT_COUNT];
  pointer_result_t       pointer_q [$];
  int unsigned           mismatch_cnt;

  // Full product, then saturate anything past the last pixel.
  function automatic logic [15:0] to_pixel(logic [16:0] norm, logic [15:0] size);
    logic [32:0] prod;
    prod = norm * size;
    if (prod[32]) begin
      return 16'hFFFF;
    end
    return prod[31:16];
  endfunction

  task automatic map_touch(input logic [1:0] kind, input logic [63:0] id,
                           input logic [16:0] nx, input logic [16:0] ny);
    pointer_result_t res;
    logic            found;
    int              hit;
    int              i;
    found      = 1'b0;
    hit        = 0;
    res.action = ACT_CANCEL;
    res.slot   = '0;
    case (kind)
      KIND_DOWN: begin
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (!found && !busy_slots[i]) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (found) begin
          res.action      = (busy_slots != '0) ? ACT_PTR_DOWN : ACT_DOWN;
          held_id[hit]    = id;
          busy_slots[hit] = 1'b1;
        end
      end
      KIND_UP, KIND_MOVE: begin
        // lowest busy slot holding the id wins
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (!found && busy_slots[i] && held_id[i] == id) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (found && kind == KIND_UP) begin
          busy_slots[hit] = 1'b0;
          res.action      = (busy_slots != '0) ? ACT_PTR_UP : ACT_UP;
        end else if (found) begin
          res.action = ACT_MOVE;
        end
      end
      default: begin
        // undefined kind: dropped, no result
        return;
      end
    endcase
    if (found) begin
      res.slot = 4'(hit);
    end else begin
      busy_slots = '0;
    end
    res.px = to_pixel(nx, screen_w);
    res.py = to_pixel(ny, screen_h);
    pointer_q.push_back(res);
  endtask

  task automatic check_pointer();
    pointer_result_t want;
    if (pointer_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= ReportLimit) begin
        $display("%0t: result with none outstanding: action %0d slot %0d x %0d y %0d",
                 $time, action_i, pointer_index_i, point_x_i, point_y_i);
      end
    end else begin
      want = pointer_q.pop_front();
      if (action_i !== want.action || pointer_index_i !== want.slot ||
          point_x_i !== want.px || point_y_i !== want.py) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportLimit) begin
          $display("%0t: result mismatch: expected action %0d slot %0d x %0d y %0d",
                   $time, want.action, want.slot, want.px, want.py);
          $display("%0t:                  actual   action %0d slot %0d x %0d y %0d",
                   $time, action_i, pointer_index_i, point_x_i, point_y_i);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w     = '0;
      screen_h     = '0;
      busy_slots   = '0;
      mismatch_cnt = 0;
      pointer_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgScreenWidth) begin
          screen_w = cfg_data_i;
        end else begin
          screen_h = cfg_data_i;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        check_pointer();
      end
      if (in_valid_i && !in_stall_i) begin
        map_touch(event_kind_i, finger_id_i, pos_x_norm_i, pos_y_norm_i);
      end
    end
    fail_count_o = mismatch_cnt;
    pending_o    = pointer_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the touch pointer slot allocator.
// Drives directed touch sequences, then random down/up/move sequences with
// noise under several screen sizes, with random gaps and output stalls. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsa_pkg::*;

  localparam int          SlotCount      = SlotCountDefault;
  localparam int unsigned IdleLimit      = 5000;
  localparam int unsigned SettleCycles   = 20;
  localparam int unsigned TailCycles     = 30;
  localparam int unsigned RandomPerPhase = 265;
  localparam int unsigned PhaseCount     = 5;
  localparam logic [1:0]  KindUndefined  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  event_kind_i;
  logic [63:0] finger_id_i;
  logic [16:0] pos_x_norm_i;
  logic [16:0] pos_y_norm_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  action_o;
  logic [3:0]  pointer_index_o;
  logic [15:0] point_x_o;
  logic [15:0] point_y_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles;
  bit          sender_calm;
  logic [63:0] live_ids [$];

  touch_pointer_slot_allocator_core #(
    .SLOT_COUNT(SlotCount)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .event_kind_i   (event_kind_i),
    .finger_id_i    (finger_id_i),
    .pos_x_norm_i   (pos_x_norm_i),
    .pos_y_norm_i   (pos_y_norm_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .pointer_index_o(pointer_index_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o)
  );

  touch_result_checker #(
    .SLOT_COUNT(SlotCount)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .event_kind_i   (event_kind_i),
    .finger_id_i    (finger_id_i),
    .pos_x_norm_i   (pos_x_norm_i),
    .pos_y_norm_i   (pos_y_norm_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_i       (action_o),
    .pointer_index_i(pointer_index_o),
    .point_x_i      (point_x_o),
    .point_y_i      (point_y_o),
    .fail_count_o   (mismatches),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Mostly short holds, now and then a long one.
  function automatic int unsigned pick_run();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 50);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_gap();
    if (sender_calm) begin
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 50);
    end
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [16:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      return 17'($urandom_range(65537, 131071));
    end
    if (r < 10) begin
      return 17'h1FFFF;
    end
    if (r < 12) begin
      return 17'h10000;
    end
    if (r < 14) begin
      return 17'h0;
    end
    return 17'($urandom_range(0, 65536));
  endfunction

  function automatic logic [63:0] pick_id();
    return {$urandom, $urandom};
  endfunction

  // Output stall: alternate calm stretches with random holds.
  int unsigned stretch_left;
  int unsigned hold_left;
  bit          stall_calm;
  bit          hold_val;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stall_calm   = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(200, 600);
      end
      stretch_left--;
      if (stall_calm) begin
        out_stall_i <= 1'b0;
      end else begin
        if (hold_left == 0) begin
          hold_val  = $urandom_range(0, 1);
          hold_left = pick_run();
        end
        hold_left--;
        out_stall_i <= hold_val;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one request and hold it until accepted, then leave a random gap, possibly none.
  task automatic send_touch(input logic [1:0] kind, input logic [63:0] id,
                            input logic [16:0] nx, input logic [16:0] ny);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    event_kind_i <= kind;
    finger_id_i  <= id;
    pos_x_norm_i <= nx;
    pos_y_norm_i <= ny;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write both registers once the block has gone quiet.
  task automatic configure(input logic [15:0] w, input logic [15:0] h);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgScreenWidth;
    cfg_data_i  <= w;
    @(negedge clk_i);
    cfg_index_i <= CfgScreenHeight;
    cfg_data_i  <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic directed_touches();
    logic [63:0] dup_id;
    int          i;
    dup_id = 64'h5;
    send_touch(KIND_DOWN, 64'h0, 17'h0, 17'h0);
    send_touch(KIND_DOWN, '1, 17'h10000, 17'h10000);
    send_touch(KIND_MOVE, 64'h0, 17'h1FFFF, 17'h1FFFF);
    send_touch(KindUndefined, 64'h0, 17'h1FFFF, 17'h0);
    send_touch(KIND_UP, 64'h0, 17'h8000, 17'h4000);
    send_touch(KIND_UP, '1, 17'h0, 17'h1FFFF);
    // same id in two slots: lookups hit the lower one first
    send_touch(KIND_DOWN, dup_id, 17'h1234, 17'h4321);
    send_touch(KIND_DOWN, dup_id, 17'h1, 17'hFFFF);
    send_touch(KIND_MOVE, dup_id, 17'hFFFF, 17'h1);
    send_touch(KIND_UP, dup_id, 17'h10001, 17'h0);
    send_touch(KIND_MOVE, dup_id, 17'h0, 17'h10001);
    send_touch(KIND_UP, dup_id, 17'h0, 17'h0);
    // unknown id on an empty table
    send_touch(KIND_MOVE, 64'h8000_0000_0000_0000, 17'h100, 17'h200);
    send_touch(KIND_UP, 64'h1, 17'h300, 17'h400);
    // fill every slot, then overflow
    for (i = 0; i < SlotCount; i++) begin
      send_touch(KIND_DOWN, 64'(i) << (i * 6), pick_pos(), pick_pos());
    end
    send_touch(KIND_DOWN, 64'hDEAD_BEEF, 17'h1FFFF, 17'h10000);
    send_touch(KIND_MOVE, 64'h1 << 6, 17'h0, 17'h0);
  endtask

  task automatic random_touches(input int unsigned count);
    int unsigned done;
    int unsigned r;
    int unsigned pick;
    int          j;
    logic [63:0] id;
    logic [1:0]  kind;
    bit          want_down;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_touch(KindUndefined, pick_id(), pick_pos(), pick_pos());
        continue;
      end
      done++;
      if (done % 90 == 0) begin
        sender_calm = ($urandom_range(0, 2) == 0);
      end
      if (done % 120 == 0) begin
        drain();
      end
      j = (live_ids.size() > 0) ? $urandom_range(0, live_ids.size() - 1) : 0;
      if (r < 8) begin
        // unknown id, often a single bit away from a live one
        if (live_ids.size() > 0 && $urandom_range(0, 1) == 1) begin
          id = live_ids[j] ^ (64'h1 << $urandom_range(0, 63));
        end else begin
          id = pick_id();
        end
        kind = $urandom_range(0, 1) ? KIND_UP : KIND_MOVE;
        send_touch(kind, id, pick_pos(), pick_pos());
        live_ids.delete();
      end else if (r < 11 && live_ids.size() > 0 && live_ids.size() < SlotCount) begin
        send_touch(KIND_DOWN, live_ids[j], pick_pos(), pick_pos());
        live_ids.push_back(live_ids[j]);
      end else begin
        pick = $urandom_range(0, 99);
        if (live_ids.size() == 0) begin
          want_down = 1'b1;
        end else if (live_ids.size() < 5) begin
          want_down = (pick < 60);
        end else if (live_ids.size() < SlotCount) begin
          want_down = (pick < 45);
        end else begin
          want_down = (pick < 25);
        end
        if (want_down) begin
          id = pick_id();
          send_touch(KIND_DOWN, id, pick_pos(), pick_pos());
          if (live_ids.size() == SlotCount) begin
            live_ids.delete();
          end else begin
            live_ids.push_back(id);
          end
        end else begin
          kind = $urandom_range(0, 1) ? KIND_UP : KIND_MOVE;
          send_touch(kind, live_ids[j], pick_pos(), pick_pos());
          if (kind == KIND_UP) begin
            live_ids.delete(j);
          end
        end
      end
    end
  endtask

  initial begin
    int unsigned phase;
    logic [15:0] w;
    logic [15:0] h;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CfgScreenWidth;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    event_kind_i = KIND_DOWN;
    finger_id_i  = '0;
    pos_x_norm_i = '0;
    pos_y_norm_i = '0;
    out_stall_i  = 1'b0;
    idle_cycles  = 0;
    stretch_left = 0;
    hold_left    = 0;
    sender_calm  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    configure(16'hFFFF, 16'hFFFF);
    directed_touches();

    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          w = 16'h0;
          h = 16'h0;
        end
        1: begin
          w = 16'd1920;
          h = 16'd1080;
        end
        2: begin
          w = 16'h1;
          h = 16'hFFFF;
        end
        3: begin
          w = 16'hFFFF;
          h = 16'hFFFF;
        end
        default: begin
          w = 16'($urandom_range(0, 65535));
          h = 16'($urandom_range(0, 65535));
        end
      endcase
      configure(w, h);
      live_ids.delete();
      random_touches(RandomPerPhase);
    end

    drain();
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
